// ===== hdl/bhi_pkg.sv =====
// Shared constants and types for the barometric height core.
package bhi_pkg;

   localparam int LogFracBits = 24;
   localparam int LgWidth     = 5 + LogFracBits;
   localparam int LnWidth     = 34;
   localparam logic [29:0] Ln2Q30 = 30'd744261118;
   localparam logic [26:0] HeightLimit = 27'd100000000;
   localparam logic [23:0] GasScaleReset = 24'd1914068;

   typedef enum logic [1:0] {
      STAT_WARMUP  = 2'd0,
      STAT_REF     = 2'd1,
      STAT_HEIGHT  = 2'd2,
      STAT_ZERO    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_NONE = 2'd0,
      PH_WARM = 2'd1,
      PH_REF  = 2'd2
   } phase_type;

endpackage

// ===== hdl/bhi_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
module bhi_mul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);
   logic [63:0] p_ff;
   logic [63:0] p_in;

   // Form the product and register it
   assign p_in = {32'd0, a} * {32'd0, b};

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;
endmodule

// ===== hdl/barometric_height_isothermal_core.sv =====
// Top level: sequencer for the isothermal barometric height core.
//
// Usage: an item on req_ (pressure_raw, temperature_raw) is taken when
// req_valid and req_ready are high. One result (height_mm, status) leaves on
// rsp_ under valid/ready. csr_we writes gas_scale (24 bits) whenever it is
// high; it is to be used only between items, which the block does not enforce.
// A zero pressure or warm-up item goes straight to the result. Other items
// take the log: a normalization step, then one shared-multiplier square per
// fraction bit (24 bits). The ln-2 scale is formed as four 32x32 partial
// products, each issued and then accumulated, and a branch step follows;
// a reference item returns there. A height item adds two more products
// (|T| x 10 x gas_scale, then that by |dln|) and a saturation step.
// One item at a time: req_ready is low from acceptance until the result has
// been taken.
// While the receiver stalls the result is held on rsp_.
// Reset clears the phase (next nonzero item is a warm-up), the reference log
// and the gas_scale register to its default; in-flight work is dropped.
module barometric_height_isothermal_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_pressure_raw,
   input  logic signed [31:0] req_temperature_raw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [27:0] rsp_height_mm,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [23:0]        csr_wdata
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_NORM  = 10'b0000000010,
      S_SQ    = 10'b0000000100,
      S_SQW   = 10'b0000001000,
      S_LN    = 10'b0000010000,
      S_KMUL  = 10'b0000100000,
      S_HMUL  = 10'b0001000000,
      S_HW    = 10'b0010000000,
      S_SAT   = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [bhi_pkg::LnWidth-1:0] ref_ln_ff, ref_ln_in;
   logic [23:0] gas_ff, gas_in;
   logic [31:0] p_ff, p_in;
   logic signed [32:0] t_ff, t_in;
   logic [32:0] m_ff, m_in;
   logic [bhi_pkg::LgWidth-1:0] lg_ff, lg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  sub_ff, sub_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0] xa_ff, xa_in;
   logic [63:0] xb_ff, xb_in;
   logic        neg_ff, neg_in;
   logic        rv_ff, rv_in;
   logic signed [27:0] h_ff, h_in;
   logic [1:0]  st_ff, st_in;
   logic [31:0] ma, mb;
   logic [63:0] mp;
   logic [4:0]  lead;
   logic [63:0] sq;
   logic [bhi_pkg::LnWidth-1:0] ln_val;
   logic signed [bhi_pkg::LnWidth:0] dln;
   logic [127:0] shifted;

   bhi_mul u_mul (.clock(clock), .a(ma), .b(mb), .p(mp));

   // Leading-one position of the pressure
   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (p_ff[i]) lead = 5'(i);
      end
   end

   // Multiplier operand select: squares in log, partial products elsewhere
   always_comb begin
      ma = m_ff[31:0];
      mb = m_ff[31:0];
      if (state_ff == S_LN || state_ff == S_KMUL || state_ff == S_HMUL) begin
         ma = sub_ff[1] ? xa_ff[63:32] : xa_ff[31:0];
         mb = sub_ff[0] ? xb_ff[63:32] : xb_ff[31:0];
      end
   end

   assign sq = mp >> 31;
   assign ln_val = bhi_pkg::LnWidth'((acc_ff + (128'd1 << 29)) >> 30);
   assign dln = $signed({1'b0, ref_ln_ff}) - $signed({1'b0, ln_val});
   assign shifted = acc_ff >> (16 + bhi_pkg::LogFracBits);

   // Sequence one item through the shared multiplier
   always_comb begin
      state_in = state_ff; phase_in = phase_ff; ref_ln_in = ref_ln_ff;
      gas_in = csr_we ? csr_wdata : gas_ff;
      p_in = p_ff; t_in = t_ff; m_in = m_ff; lg_in = lg_ff; cnt_in = cnt_ff;
      sub_in = sub_ff; acc_in = acc_ff; xa_in = xa_ff; xb_in = xb_ff;
      neg_in = neg_ff; rv_in = rv_ff; h_in = h_ff; st_in = st_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               p_in = req_pressure_raw;
               t_in = 33'(req_temperature_raw) + 33'sd27315;
               h_in = '0;
               if (req_pressure_raw == 32'd0) begin
                  st_in = bhi_pkg::STAT_ZERO; rv_in = 1'b1; state_in = S_OUT;
               end else if (phase_ff == bhi_pkg::PH_NONE) begin
                  phase_in = bhi_pkg::PH_WARM;
                  st_in = bhi_pkg::STAT_WARMUP; rv_in = 1'b1; state_in = S_OUT;
               end else begin
                  state_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            m_in = {1'b0, p_ff << (5'd31 - lead)};
            lg_in = bhi_pkg::LgWidth'(lead);
            cnt_in = '0;
            state_in = S_SQ;
         end
         S_SQ: state_in = S_SQW;
         S_SQW: begin
            lg_in = {lg_ff[bhi_pkg::LgWidth-2:0], sq[32]};
            m_in = sq[32] ? sq[33:1] : sq[32:0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(bhi_pkg::LogFracBits - 1)) begin
               xa_in = {{(64-bhi_pkg::LgWidth){1'b0}},
                        lg_ff[bhi_pkg::LgWidth-2:0], sq[32]};
               xb_in = 64'(bhi_pkg::Ln2Q30);
               acc_in = '0; sub_in = '0; cnt_in = '0;
               state_in = S_LN;
            end else begin
               state_in = S_SQ;
            end
         end
         S_LN, S_KMUL, S_HMUL: begin
            // Per partial product: issue, then accumulate
            if (cnt_ff[0]) begin
               acc_in = acc_ff + (128'(mp) << (7'({sub_ff[1], 5'd0}) +
                                               7'({sub_ff[0], 5'd0})));
               sub_in = sub_ff + 2'd1;
               cnt_in = '0;
               if (sub_ff == 2'd3) begin
                  sub_in = '0;
                  if (state_ff == S_LN) begin
                     state_in = S_HW;
                  end else if (state_ff == S_KMUL) begin
                     xa_in = acc_in[63:0];
                     state_in = S_HMUL;
                     acc_in = '0;
                  end else begin
                     state_in = S_SAT;
                  end
               end
            end else begin
               cnt_in = 5'd1;
            end
         end
         S_HW: begin
            if (phase_ff == bhi_pkg::PH_WARM) begin
               ref_ln_in = ln_val; phase_in = bhi_pkg::PH_REF;
               st_in = bhi_pkg::STAT_REF; rv_in = 1'b1; state_in = S_OUT;
            end else begin
               // Load |T| and 10 x gas_scale; keep |dln| for the second product
               neg_in = t_ff[32] ^ dln[bhi_pkg::LnWidth];
               xa_in = {31'd0, t_ff[32] ? 33'(-t_ff) : 33'(t_ff)};
               xb_in = {37'd0, gas_ff, 3'd0} + {39'd0, gas_ff, 1'd0};
               m_in = dln[bhi_pkg::LnWidth] ? 33'(-dln) : 33'(dln);
               acc_in = '0; cnt_in = '0; sub_in = '0;
               state_in = S_KMUL;
            end
         end
         S_SAT: begin
            if (shifted > 128'(bhi_pkg::HeightLimit)) begin
               h_in = neg_ff ? -28'sd100000000 : 28'sd100000000;
            end else begin
               h_in = neg_ff ? -$signed(shifted[27:0]) : $signed(shifted[27:0]);
            end
            st_in = bhi_pkg::STAT_HEIGHT; rv_in = 1'b1; state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rv_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // The second product takes |dln| from m register
      if (state_ff == S_KMUL && cnt_ff[0] && sub_ff == 2'd3) begin
         xb_in = {31'd0, m_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= bhi_pkg::PH_NONE;
         ref_ln_ff <= '0;
         gas_ff <= bhi_pkg::GasScaleReset;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ref_ln_ff <= ref_ln_in;
         gas_ff <= gas_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in; t_ff <= t_in; m_ff <= m_in; lg_ff <= lg_in;
      cnt_ff <= cnt_in; sub_ff <= sub_in; acc_ff <= acc_in;
      xa_ff <= xa_in; xb_ff <= xb_in; neg_ff <= neg_in;
      h_ff <= h_in; st_ff <= st_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_height_mm = h_ff;
   assign rsp_status = st_ff;

   // Result valid only in output state
   a_rv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == (state_ff == S_OUT)) else $error("rsp_valid mismatch");
   // Warm-up, reference and zero-pressure results carry zero height
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bhi_pkg::STAT_HEIGHT) |-> rsp_height_mm == 28'sd0)
      else $error("nonzero height");
   // Reference phase never goes back
   a_phase: assert property (@(posedge clock) disable iff (reset)
      $past(phase_ff) == bhi_pkg::PH_REF && !$past(reset) |-> phase_ff == bhi_pkg::PH_REF)
      else $error("phase regressed");

endmodule
